>>> rtl/core/clt_pkg.sv
// Package for the command line tokenizer.
// Holds the scan mode codes, byte constants and the state and result structs.
// No dependencies.
package clt_pkg;

    // Scan mode codes
    localparam logic [2:0] MODE_BETWEEN    = 3'd0;
    localparam logic [2:0] MODE_AFTER_GT   = 3'd1;
    localparam logic [2:0] MODE_WORD       = 3'd2;
    localparam logic [2:0] MODE_QUOTED     = 3'd3;
    localparam logic [2:0] MODE_ESC_WORD   = 3'd4;
    localparam logic [2:0] MODE_ESC_QUOTED = 3'd5;

    // Target list codes
    localparam logic [1:0] LIST_ARGS   = 2'd0;
    localparam logic [1:0] LIST_INPUT  = 2'd1;
    localparam logic [1:0] LIST_OUTPUT = 2'd2;
    localparam logic [1:0] LIST_ERROR  = 2'd3;

    // Byte constants
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] list;
        logic [3:0] stage;
    } clt_state_t;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_out;
        logic       word_end;
        logic       line_end;
        logic [1:0] target_list;
        logic [3:0] stage_index;
    } clt_result_t;

    localparam clt_state_t STATE_RESET = '{mode: MODE_BETWEEN, list: LIST_ARGS, stage: 4'd0};

endpackage

>>> rtl/core/clt_scan.sv
// Scan step of the command line tokenizer: next state and result for one byte.
// Purely combinational. Depends on clt_pkg.
module clt_scan #(
    parameter logic [3:0] STAGE_CAP = 4'd15
) (
    input  logic [7:0]          char_in,
    input  clt_pkg::clt_state_t state_in,
    output clt_pkg::clt_state_t state_next,
    output logic                res_valid,
    output clt_pkg::clt_result_t res
);
    import clt_pkg::*;

    logic       blank;
    logic       bang_done;
    logic [2:0] mode_eff;
    logic [1:0] list_eff;

    assign blank = (char_in == CHAR_SPACE) || (char_in >= CHAR_TAB && char_in <= CHAR_CR);

    // Resolve a pending '>' before the main scan
    always_comb begin
        bang_done = 1'b0;
        mode_eff  = state_in.mode;
        list_eff  = state_in.list;
        if (state_in.mode == MODE_AFTER_GT) begin
            mode_eff = MODE_BETWEEN;
            if (char_in == CHAR_BANG) begin
                bang_done = 1'b1;
                list_eff  = LIST_ERROR;
            end else begin
                list_eff = LIST_OUTPUT;
            end
        end
    end

    // Main scan
    always_comb begin
        state_next      = '{mode: mode_eff, list: list_eff, stage: state_in.stage};
        res_valid       = 1'b0;
        res             = '0;
        res.target_list = list_eff;
        res.stage_index = state_in.stage;
        if (!bang_done) begin
            case (mode_eff)
                MODE_BETWEEN: begin
                    if (char_in == CHAR_NUL) begin
                        state_next      = STATE_RESET;
                        res_valid       = 1'b1;
                        res.line_end    = 1'b1;
                        res.target_list = LIST_ARGS;
                        res.stage_index = 4'd0;
                    end else if (blank) begin
                        state_next.mode = MODE_BETWEEN;
                    end else if (char_in == CHAR_LT) begin
                        state_next.list = LIST_INPUT;
                    end else if (char_in == CHAR_GT) begin
                        state_next.mode = MODE_AFTER_GT;
                    end else if (char_in == CHAR_PIPE) begin
                        if (state_in.stage < STAGE_CAP) begin
                            state_next.stage = state_in.stage + 4'd1;
                        end
                        state_next.list = LIST_ARGS;
                    end else if (char_in == CHAR_QUOTE) begin
                        state_next.mode = MODE_QUOTED;
                    end else if (char_in == CHAR_BSL) begin
                        state_next.mode = MODE_ESC_WORD;
                    end else begin
                        state_next.mode = MODE_WORD;
                        res_valid       = 1'b1;
                        res.has_char    = 1'b1;
                        res.char_out    = char_in;
                    end
                end
                MODE_WORD, MODE_QUOTED: begin
                    if (char_in == CHAR_NUL) begin
                        state_next   = STATE_RESET;
                        res_valid    = 1'b1;
                        res.word_end = 1'b1;
                        res.line_end = 1'b1;
                    end else if (char_in == CHAR_BSL) begin
                        state_next.mode = (mode_eff == MODE_WORD) ? MODE_ESC_WORD
                                                                  : MODE_ESC_QUOTED;
                    end else if ((mode_eff == MODE_WORD && blank) ||
                                 (mode_eff == MODE_QUOTED && char_in == CHAR_QUOTE)) begin
                        state_next.mode = MODE_BETWEEN;
                        res_valid       = 1'b1;
                        res.word_end    = 1'b1;
                    end else begin
                        res_valid    = 1'b1;
                        res.has_char = 1'b1;
                        res.char_out = char_in;
                    end
                end
                MODE_ESC_WORD, MODE_ESC_QUOTED: begin
                    if (char_in == CHAR_NUL) begin
                        state_next   = STATE_RESET;
                        res_valid    = 1'b1;
                        res.word_end = 1'b1;
                        res.line_end = 1'b1;
                    end else begin
                        state_next.mode = (mode_eff == MODE_ESC_WORD) ? MODE_WORD
                                                                      : MODE_QUOTED;
                        res_valid       = 1'b1;
                        res.has_char    = 1'b1;
                        res.char_out    = char_in;
                    end
                end
                default: begin
                    // Unused mode codes: fall back to reset, drop the byte
                    state_next = STATE_RESET;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/command_line_tokenizer.sv
// Command line tokenizer. Takes one byte per transaction (0 ends the line) and
// gives at most one result per byte, loaded into the result register at the edge
// at which the byte leaves the input register: word bytes tagged with list and
// pipe stage, word end and line end marks. The rate is one byte per cycle while
// no byte with a result is held back, set by the single scan step between the
// input register and the result register, whose state feedback closes within
// that cycle. A byte that has a result waits in the input register only while the
// result register is full and m_ready is low. A result is presented on the m_
// side from the result register after its byte has passed the input register.
// Bytes that cause no result (white space, operators, escapes) are absorbed
// without a transaction on m_.
// Depends on clt_pkg and clt_scan.
module command_line_tokenizer #(
    parameter int MAX_STAGES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_has_char,
    output logic [7:0] m_char_out,
    output logic       m_word_end,
    output logic       m_line_end,
    output logic [1:0] m_target_list,
    output logic [3:0] m_stage_index
);
    import clt_pkg::*;

    localparam int         CAP_INT   = (MAX_STAGES - 1 > 15) ? 15 : MAX_STAGES - 1;
    localparam logic [3:0] STAGE_CAP = CAP_INT[3:0];

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    clt_state_t  state_reg;
    clt_state_t  state_next;
    logic        res_valid;
    clt_result_t res;
    logic        out_valid_reg;
    clt_result_t out_reg;
    logic        out_free;
    logic        advance;

    // Scan step
    clt_scan #(
        .STAGE_CAP(STAGE_CAP)
    ) u_scan (
        .char_in   (char_reg),
        .state_in  (state_reg),
        .state_next(state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // Flow control: the held byte advances once its result, if any, has room
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            char_reg <= s_char_in;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res_valid;
        end
        if (out_free && advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_has_char    = out_reg.has_char;
    assign m_char_out    = out_reg.char_out;
    assign m_word_end    = out_reg.word_end;
    assign m_line_end    = out_reg.line_end;
    assign m_target_list = out_reg.target_list;
    assign m_stage_index = out_reg.stage_index;

    // A line end returns the scan state to reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && res.line_end) |=> (state_reg == STATE_RESET))
        else $error("scan state not cleared after line end");

    // Stage count never passes its bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.stage <= STAGE_CAP))
        else $error("stage count above bound");

    // A held byte is not overwritten while it waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(char_reg)))
        else $error("input register lost a waiting byte");

    // A bare line end carries argument list and stage zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.line_end && !out_reg.word_end) |->
        (out_reg.target_list == LIST_ARGS && out_reg.stage_index == 4'd0 &&
         !out_reg.has_char))
        else $error("bare line end carries word tags");

endmodule

>>> dv/tb_top.sv
// Testbench for command_line_tokenizer: byte stream in, word bytes and marks out.
// Depends on clt_pkg and the command_line_tokenizer RTL; scoreboard class is local.
`timescale 1ns / 1ps

module tb_top;
    import clt_pkg::*;

    localparam int STAGE_BOUND = 16;
    localparam int STAGE_CAP   = (STAGE_BOUND - 1 > 15) ? 15 : STAGE_BOUND - 1;
    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_LIMIT = 5000;

    // Directed line set: empty line, operators inside and at word start, '>' then '!'
    // split by a blank, empty quoted word, escaped quote, closing quote glued to a
    // word, backslash before line end, operator at line end.
    localparam logic [7:0] DIRECTED [30] = '{
        CHAR_NUL,
        8'h78, 8'hFF, CHAR_LT, CHAR_SPACE,
        CHAR_LT, 8'h61, CHAR_CR,
        CHAR_GT, CHAR_BANG, 8'h65, CHAR_TAB,
        CHAR_GT, CHAR_SPACE, CHAR_BANG, 8'h6F, CHAR_SPACE,
        CHAR_PIPE, CHAR_QUOTE, CHAR_QUOTE,
        CHAR_QUOTE, 8'h71, CHAR_BSL, CHAR_QUOTE, CHAR_QUOTE, 8'h77,
        CHAR_BSL, CHAR_NUL,
        CHAR_PIPE, CHAR_NUL
    };

    // Tracks tokenizer state and holds the results each accepted byte should produce
    class token_scoreboard;
        logic [2:0]  mode;
        logic [1:0]  list;
        logic [3:0]  stage;
        clt_result_t expected_tokens[$];
        int          errors;

        function new();
            clear_line();
            errors = 0;
        endfunction

        function void clear_line();
            mode  = MODE_BETWEEN;
            list  = LIST_ARGS;
            stage = 4'd0;
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
        endfunction

        static function clt_result_t token(logic hc, logic [7:0] ch, logic we, logic le,
                                           logic [1:0] tl, logic [3:0] st);
            clt_result_t r;
            r.has_char    = hc;
            r.char_out    = ch;
            r.word_end    = we;
            r.line_end    = le;
            r.target_list = tl;
            r.stage_index = st;
            return r;
        endfunction

        // Advance the state by one byte; return 1 when a result is due
        function bit scan_byte(input logic [7:0] c, output clt_result_t r);
            logic [1:0] tl;
            logic [3:0] st;
            tl = list;
            st = stage;
            r  = '0;
            // resolve '>' against the byte after it
            if (mode == MODE_AFTER_GT) begin
                mode = MODE_BETWEEN;
                if (c == CHAR_BANG) begin
                    list = LIST_ERROR;
                    return 0;
                end
                list = LIST_OUTPUT;
                tl   = LIST_OUTPUT;
            end
            case (mode)
                MODE_BETWEEN: begin
                    if (c == CHAR_NUL) begin
                        clear_line();
                        r = token(1'b0, 8'h00, 1'b0, 1'b1, LIST_ARGS, 4'd0);
                        return 1;
                    end
                    if (is_blank(c)) return 0;
                    if (c == CHAR_LT) begin
                        list = LIST_INPUT;
                        return 0;
                    end
                    if (c == CHAR_GT) begin
                        mode = MODE_AFTER_GT;
                        return 0;
                    end
                    if (c == CHAR_PIPE) begin
                        if (stage < STAGE_CAP) stage = stage + 4'd1;
                        list = LIST_ARGS;
                        return 0;
                    end
                    if (c == CHAR_QUOTE) begin
                        mode = MODE_QUOTED;
                        return 0;
                    end
                    if (c == CHAR_BSL) begin
                        mode = MODE_ESC_WORD;
                        return 0;
                    end
                    mode = MODE_WORD;
                    r = token(1'b1, c, 1'b0, 1'b0, tl, st);
                    return 1;
                end
                MODE_WORD, MODE_QUOTED: begin
                    if (c == CHAR_NUL) begin
                        clear_line();
                        r = token(1'b0, 8'h00, 1'b1, 1'b1, tl, st);
                        return 1;
                    end
                    if (c == CHAR_BSL) begin
                        mode = (mode == MODE_WORD) ? MODE_ESC_WORD : MODE_ESC_QUOTED;
                        return 0;
                    end
                    if ((mode == MODE_WORD && is_blank(c)) ||
                        (mode == MODE_QUOTED && c == CHAR_QUOTE)) begin
                        mode = MODE_BETWEEN;
                        r = token(1'b0, 8'h00, 1'b1, 1'b0, tl, st);
                        return 1;
                    end
                    r = token(1'b1, c, 1'b0, 1'b0, tl, st);
                    return 1;
                end
                MODE_ESC_WORD, MODE_ESC_QUOTED: begin
                    // an escape cut short by the line end just closes the word
                    if (c == CHAR_NUL) begin
                        clear_line();
                        r = token(1'b0, 8'h00, 1'b1, 1'b1, tl, st);
                        return 1;
                    end
                    mode = (mode == MODE_ESC_WORD) ? MODE_WORD : MODE_QUOTED;
                    r = token(1'b1, c, 1'b0, 1'b0, tl, st);
                    return 1;
                end
                default: begin
                    clear_line();
                    return 0;
                end
            endcase
        endfunction

        function void note_char(logic [7:0] c);
            clt_result_t r;
            if (scan_byte(c, r)) expected_tokens.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_token(clt_result_t got);
            clt_result_t want;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got 0x%0h", $time, got);
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("has_char", want.has_char, got.has_char);
            compare_field("char_out", want.char_out, got.char_out);
            compare_field("word_end", want.word_end, got.word_end);
            compare_field("line_end", want.line_end, got.line_end);
            compare_field("target_list", want.target_list, got.target_list);
            compare_field("stage_index", want.stage_index, got.stage_index);
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void flag_leftover();
            if (expected_tokens.size() != 0) begin
                errors++;
                $display("%0t: results expected %0d more, got 0", $time,
                         expected_tokens.size());
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_in;
    logic        m_valid;
    logic        m_ready;
    logic        m_has_char;
    logic [7:0]  m_char_out;
    logic        m_word_end;
    logic        m_line_end;
    logic [1:0]  m_target_list;
    logic [3:0]  m_stage_index;
    clt_result_t seen_token;

    token_scoreboard sb = new();
    logic [7:0]      line_bytes[$];
    int              sent_items;
    int              quiet_cycles;
    bit              steady;
    bit              paused;

    command_line_tokenizer #(
        .MAX_STAGES(STAGE_BOUND)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_has_char    (m_has_char),
        .m_char_out    (m_char_out),
        .m_word_end    (m_word_end),
        .m_line_end    (m_line_end),
        .m_target_list (m_target_list),
        .m_stage_index (m_stage_index)
    );

    assign seen_token = {m_has_char, m_char_out, m_word_end, m_line_end,
                         m_target_list, m_stage_index};

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Stall the result channel at random, except through the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    // Log accepted bytes, check accepted results, and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_char_in);
            if (m_valid && m_ready) sb.check_token(seen_token);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_char(input logic [7:0] c);
        if (!steady) begin
            while ($urandom_range(0, 99) < 12) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_char_in <= c;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(0, 5);
        if (k == 5) return CHAR_SPACE;
        return CHAR_TAB + 8'(k);
    endfunction

    // Word start byte that is not an operator, quote or escape
    function automatic logic [7:0] pick_lead();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (c == CHAR_QUOTE || c == CHAR_BSL || c == CHAR_LT ||
               c == CHAR_GT || c == CHAR_PIPE);
        return c;
    endfunction

    function automatic logic [7:0] pick_inner();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (token_scoreboard::is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_quoted();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE || c == CHAR_BSL);
        return c;
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 6);
        line_bytes.push_back(pick_lead());
        repeat (n - 1) line_bytes.push_back(pick_inner());
    endfunction

    // Quoted word with occasional escapes; now and then left unterminated
    function automatic void add_quoted();
        line_bytes.push_back(CHAR_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 5) == 0) begin
                line_bytes.push_back(CHAR_BSL);
                line_bytes.push_back(8'($urandom_range(1, 255)));
            end else begin
                line_bytes.push_back(pick_quoted());
            end
        end
        if ($urandom_range(0, 99) < 85) line_bytes.push_back(CHAR_QUOTE);
    endfunction

    // Build one line: mostly well-formed commands, some long pipelines, some noise
    function automatic void build_line();
        int kind;
        line_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 24)) line_bytes.push_back(8'($urandom_range(1, 255)));
            line_bytes.push_back(CHAR_NUL);
            return;
        end
        if (kind < 20) begin
            // enough stages to run the stage count into saturation
            repeat ($urandom_range(14, 20)) begin
                add_word();
                line_bytes.push_back(CHAR_SPACE);
                line_bytes.push_back(CHAR_PIPE);
                line_bytes.push_back(pick_blank());
            end
            add_word();
            line_bytes.push_back(CHAR_NUL);
            return;
        end
        if ($urandom_range(0, 3) == 0) line_bytes.push_back(pick_blank());
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_word();
                4: add_quoted();
                5: begin
                    line_bytes.push_back(CHAR_BSL);
                    line_bytes.push_back(8'($urandom_range(1, 255)));
                    if ($urandom_range(0, 1)) line_bytes.push_back(pick_inner());
                end
                6: line_bytes.push_back(CHAR_LT);
                7: line_bytes.push_back(CHAR_GT);
                8: begin
                    line_bytes.push_back(CHAR_GT);
                    line_bytes.push_back(CHAR_BANG);
                end
                default: line_bytes.push_back(CHAR_PIPE);
            endcase
            repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
        end
        // end the line after a dangling escape or operator now and then
        case ($urandom_range(0, 9))
            0: line_bytes.push_back(CHAR_BSL);
            1: line_bytes.push_back(CHAR_PIPE);
            2: line_bytes.push_back(CHAR_GT);
            default: ;
        endcase
        line_bytes.push_back(CHAR_NUL);
    endfunction

    initial begin
        s_valid      <= 1'b0;
        s_char_in    <= 8'h00;
        m_ready      <= 1'b0;
        aresetn      <= 1'b0;
        quiet_cycles <= 0;
        steady     = 1'b0;
        paused     = 1'b0;
        sent_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_char(DIRECTED[i]);

        while (sent_items < ITEM_TARGET) begin
            steady = (sent_items >= 500 && sent_items < 800);
            // hold the sender once until every result has drained
            if (!paused && sent_items >= 1000) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
            end
            build_line();
            foreach (line_bytes[i]) send_char(line_bytes[i]);
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // drain, then allow the pipeline latency to pass
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> command_line_tokenizer.f
rtl/core/clt_pkg.sv
rtl/core/clt_scan.sv
rtl/core/command_line_tokenizer.sv
dv/tb_top.sv
